// ===== src/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and lead-byte decode for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CodeWidth = 42;
   localparam int LenWidth  = 4;
   localparam int PendWidth = 3;

   // Longest sequence accepted; longer leads are dropped like stray bytes.
   localparam logic [LenWidth-1:0] MaxSeqBytes = 4'd8;

   // Lead prefixes, longest first
   localparam logic [7:0] Lead8 = 8'hFF;
   localparam logic [7:0] Lead7 = 8'hFE;
   localparam logic [7:0] Lead6 = 8'hFC;
   localparam logic [7:0] Lead5 = 8'hF8;
   localparam logic [7:0] Lead4 = 8'hF0;
   localparam logic [7:0] Lead3 = 8'hE0;
   localparam logic [7:0] Lead2 = 8'hC0;
   localparam logic [7:0] ContMask = 8'h3F;

   typedef struct packed {
      logic [LenWidth-1:0] len;      // 0 when not a lead
      logic [7:0]          payload;  // byte with prefix bits cleared
   } lead_info_type;

   typedef struct packed {
      logic                 valid;
      logic [CodeWidth-1:0] code_point;
      logic [LenWidth-1:0]  seq_bytes;
   } result_type;

   function automatic lead_info_type lead_decode(input logic [7:0] b);
      lead_info_type info;
      info.len     = '0;
      info.payload = '0;
      if ((b & Lead8) == Lead8) begin
         info.len     = 4'd8;
         info.payload = b & ~Lead8;
      end else if ((b & Lead7) == Lead7) begin
         info.len     = 4'd7;
         info.payload = b & ~Lead7;
      end else if ((b & Lead6) == Lead6) begin
         info.len     = 4'd6;
         info.payload = b & ~Lead6;
      end else if ((b & Lead5) == Lead5) begin
         info.len     = 4'd5;
         info.payload = b & ~Lead5;
      end else if ((b & Lead4) == Lead4) begin
         info.len     = 4'd4;
         info.payload = b & ~Lead4;
      end else if ((b & Lead3) == Lead3) begin
         info.len     = 4'd3;
         info.payload = b & ~Lead3;
      end else if ((b & Lead2) == Lead2) begin
         info.len     = 4'd2;
         info.payload = b & ~Lead2;
      end
      return info;
   endfunction

endpackage

// ===== src/utf8d_core.sv =====
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and per-byte step: accumulates payload, flags completion.
// ----------------------------------------------------------------------------
module utf8d_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [7:0]                   in_byte,
   input  logic                         end_of_buffer,
   output utf8d_pkg::result_type        result
);

   logic [utf8d_pkg::PendWidth-1:0] pending_ff, pending_in;
   logic [utf8d_pkg::CodeWidth-1:0] accum_ff, accum_in;
   logic [utf8d_pkg::LenWidth-1:0]  open_len_ff, open_len_in;

   utf8d_pkg::lead_info_type        lead;
   logic [utf8d_pkg::CodeWidth-1:0] shifted;
   logic [utf8d_pkg::PendWidth-1:0] pend_dec;

   always_comb begin
      lead     = utf8d_pkg::lead_decode(in_byte);
      shifted  = {accum_ff[utf8d_pkg::CodeWidth-7:0], in_byte[5:0]};
      pend_dec = pending_ff - 3'd1;

      pending_in  = pending_ff;
      accum_in    = accum_ff;
      open_len_in = open_len_ff;
      result      = '0;

      if (take) begin
         if (pending_ff != '0) begin
            // open sequence: every byte counts as a continuation
            if (pend_dec == '0) begin
               result.valid      = 1'b1;
               result.code_point = shifted;
               result.seq_bytes  = open_len_ff;
               pending_in  = '0;
               accum_in    = '0;
               open_len_in = '0;
            end else if (end_of_buffer) begin
               pending_in  = '0;
               accum_in    = '0;
               open_len_in = '0;
            end else begin
               pending_in = pend_dec;
               accum_in   = shifted;
            end
         end else if (!in_byte[7]) begin
            // ASCII passes straight through
            result.valid      = 1'b1;
            result.code_point = {{(utf8d_pkg::CodeWidth-8){1'b0}}, in_byte};
            result.seq_bytes  = 4'd1;
         end else if (lead.len == '0 || lead.len > utf8d_pkg::MaxSeqBytes
                      || end_of_buffer) begin
            // stray continuation, overlong lead, or lead cut off by end
            pending_in  = '0;
            accum_in    = '0;
            open_len_in = '0;
         end else begin
            pending_in  = utf8d_pkg::PendWidth'(lead.len - 4'd1);
            accum_in    = {{(utf8d_pkg::CodeWidth-8){1'b0}}, lead.payload};
            open_len_in = lead.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         accum_ff    <= '0;
         open_len_ff <= '0;
      end else begin
         pending_ff  <= pending_in;
         accum_ff    <= accum_in;
         open_len_ff <= open_len_in;
      end
   end

endmodule

// ===== src/utf8_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Extended UTF-8 decoder (2..8 byte sequences), one byte in per item.
// ----------------------------------------------------------------------------
// A character appears on rsp in the cycle after its last byte is taken.
// Throughput: one byte per cycle; the sequence state updates in one step per
// byte, so the only limit is the result register draining on rsp.
// Reset (synchronous, active high) closes any open sequence and empties the
// result register.
module utf8_byte_stream_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_end_of_buffer,
   // decoded characters
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [utf8d_pkg::CodeWidth-1:0]     rsp_code_point,
   output logic [utf8d_pkg::LenWidth-1:0]      rsp_seq_bytes
);

   // Result register: holds one character until rsp takes it.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [utf8d_pkg::CodeWidth-1:0]  rsp_code_ff, rsp_code_in;
   logic [utf8d_pkg::LenWidth-1:0]   rsp_len_ff, rsp_len_in;

   utf8d_pkg::result_type            step;
   logic                             take;

   // Stall input only while a finished character sits unclaimed. When the
   // register is empty or being drained this cycle, a new byte goes in.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   utf8d_core u_core (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .in_byte       (req_in_byte),
      .end_of_buffer (req_end_of_buffer),
      .result        (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_len_in   = rsp_len_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         // register free (or emptied now): load whatever this byte produced
         rsp_valid_in = step.valid;
         rsp_code_in  = step.code_point;
         rsp_len_in   = step.seq_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_code_ff;
   assign rsp_seq_bytes  = rsp_len_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for utf8_byte_stream_decoder
// Feeds raw bytes (ASCII, 2..8 byte leads, continuations, strays, truncated
// sequences) and checks every decoded character against an in-bench decoder
// model, with random sender gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module tb;

   localparam int RandomBytes = 500;
   localparam int DrainSlack  = 8;
   localparam int PrintCap    = 50;

   typedef struct packed {
      logic [utf8d_pkg::CodeWidth-1:0] code_point;
      logic [utf8d_pkg::LenWidth-1:0]  seq_bytes;
   } decoded_char_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_BURST,
      STALL_HEAVY
   } stall_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_in_byte = 8'h00;
   logic                            req_end_of_buffer = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [utf8d_pkg::CodeWidth-1:0] rsp_code_point;
   logic [utf8d_pkg::LenWidth-1:0]  rsp_seq_bytes;

   // Decoder model state
   logic [utf8d_pkg::PendWidth-1:0] dec_pend  = '0;
   logic [utf8d_pkg::CodeWidth-1:0] dec_accum = '0;
   logic [utf8d_pkg::LenWidth-1:0]  dec_len   = '0;

   decoded_char_type pending_chars[$];   // characters still owed by the DUT
   int               mismatch_count = 0;

   // Sender burst control
   int unsigned burst_left = 0;
   bit          sender_idle_on = 1'b1;

   // Receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_phase_left = 0;
   int unsigned    stall_hold = 0;

   utf8_byte_stream_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_seq_bytes     (rsp_seq_bytes)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder model: one accepted byte in, zero or one character out.
   // ------------------------------------------------------------------------
   task automatic decode_byte(input logic [7:0] b, input logic eob);
      int unsigned      ones;
      decoded_char_type ch;
      ones = 0;
      if (dec_pend != 0) begin
         // open sequence: any byte counts as a continuation, low 6 bits only
         dec_accum = {dec_accum[utf8d_pkg::CodeWidth-7:0], b[5:0]};
         dec_pend  = dec_pend - 1'b1;
         if (dec_pend == 0) begin
            ch.code_point = dec_accum;
            ch.seq_bytes  = dec_len;
            pending_chars.push_back(ch);
            dec_accum = '0;
            dec_len   = '0;
         end else if (eob) begin
            // buffer ended mid-sequence: drop it
            dec_accum = '0;
            dec_len   = '0;
            dec_pend  = '0;
         end
      end else if (!b[7]) begin
         ch.code_point = {{(utf8d_pkg::CodeWidth-8){1'b0}}, b};
         ch.seq_bytes  = 4'd1;
         pending_chars.push_back(ch);
      end else begin
         // sequence length = count of leading ones
         while (ones < 8 && b[7-ones]) ones++;
         if (ones >= 2 && ones <= utf8d_pkg::MaxSeqBytes && !eob) begin
            dec_accum = {{(utf8d_pkg::CodeWidth-8){1'b0}}, b & (8'hFF >> ones)};
            dec_pend  = utf8d_pkg::PendWidth'(ones - 1);
            dec_len   = utf8d_pkg::LenWidth'(ones);
         end
         // stray continuation or lead on the last byte: nothing opens
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PrintCap)
         $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
   endtask

   // Input monitor runs first so a same-edge result always has its entry.
   always @(posedge clock) begin : scoreboard
      decoded_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            decode_byte(req_in_byte, req_end_of_buffer);
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               report_mismatch("unexpected character", {22'd0, rsp_code_point}, 64'd0);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_code_point !== want.code_point)
                  report_mismatch("code_point", {22'd0, rsp_code_point},
                                  {22'd0, want.code_point});
               if (rsp_seq_bytes !== want.seq_bytes)
                  report_mismatch("seq_bytes", {60'd0, rsp_seq_bytes},
                                  {60'd0, want.seq_bytes});
            end
         end
      end
   end

   // Receiver backpressure: phases of no, light, bursty and heavy stalling.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(40, 200);
      end else begin
         stall_phase_left--;
      end
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_BURST: begin
               if ($urandom_range(0, 7) == 0) begin
                  stall_hold = $urandom_range(2, 12);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default:     rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sender: one item per call; returns at the accepting edge, or after a random
   // idle gap that follows it.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = (!sender_idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Hold the sender until every owed character has come out.
   task automatic wait_until_drained();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainSlack) @(posedge clock);
   endtask

   // Lead byte for an n-byte sequence with random payload bits.
   function automatic logic [7:0] lead_for(input int unsigned n);
      logic [7:0]  ones8;
      logic [31:0] r;
      ones8 = 8'hFF;
      r     = $urandom;
      return ~(ones8 >> n) | (r[7:0] & (ones8 >> (n + 1)));
   endfunction

   // Mostly proper continuations, now and then any byte at all.
   function automatic logic [7:0] cont_byte();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 9) == 0) return r[7:0];
      return {2'b10, r[5:0]};
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_bytes();
      int unsigned k;
      send_byte(8'h00, 1'b0);                 // ASCII extremes
      send_byte(8'h7F, 1'b1);                 // ASCII on end of buffer
      send_byte(8'h80, 1'b0);                 // stray continuation
      send_byte(8'hDF, 1'b0);                 // 2-byte, all payload ones
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFF, 1'b0);                 // 8-byte lead, fills all 42 bits
      for (k = 0; k < 7; k++) send_byte(8'hFF, 1'b0);
      send_byte(8'hC2, 1'b0);                 // unchecked continuation (ASCII)
      send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b1);                 // lead on last byte: dropped
      send_byte(8'hE2, 1'b0);                 // truncated 3-byte sequence
      send_byte(8'h82, 1'b1);
      send_byte(8'hC3, 1'b0);                 // completes on last byte
      send_byte(8'hA9, 1'b1);
      send_byte(8'hBF, 1'b1);                 // stray on end of buffer
   endtask

   task automatic test_random_stream();
      int unsigned sent;
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      int unsigned j;
      logic [31:0] r;
      bit          paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < RandomBytes) begin
         // every third stretch of about 100 bytes runs with no sender gaps
         sender_idle_on = ((sent / 100) % 3) != 1;
         pick = $urandom_range(0, 99);
         r    = $urandom;
         if (pick < 30) begin
            send_byte({1'b0, r[6:0]}, $urandom_range(0, 9) == 0);
            sent++;
         end else if (pick < 80) begin
            // full-length sequence, optional end of buffer on its last byte
            n = $urandom_range(2, utf8d_pkg::MaxSeqBytes);
            send_byte(lead_for(n), 1'b0);
            sent++;
            for (k = 1; k < n; k++) begin
               send_byte(cont_byte(), (k == n - 1) && ($urandom_range(0, 6) == 0));
               sent++;
            end
         end else if (pick < 88) begin
            send_byte({2'b10, r[5:0]}, r[8] & r[9]);
            sent++;
         end else if (pick < 96) begin
            // sequence cut short by end of buffer
            n = $urandom_range(2, utf8d_pkg::MaxSeqBytes);
            k = $urandom_range(0, n - 2);
            send_byte(lead_for(n), k == 0);
            sent++;
            for (j = 1; j <= k; j++) begin
               send_byte(cont_byte(), j == k);
               sent++;
            end
         end else begin
            send_byte(r[7:0], r[8]);
            sent++;
         end
         if (!paused && sent >= RandomBytes / 2) begin
            paused = 1'b1;
            wait_until_drained();
         end
      end
      sender_idle_on = 1'b1;
   endtask

   // Sender goes quiet with a sequence open; state must hold across the gap.
   task automatic test_pause_open_sequence();
      wait_until_drained();
      send_byte(8'hF1, 1'b0);
      send_byte(8'h9A, 1'b0);
      wait_until_drained();
      send_byte(8'hBC, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b0);                 // 7-byte lead, pause right after it
      wait_until_drained();
      send_byte(8'hBF, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h84, 1'b0);
      send_byte(8'h85, 1'b1);
      send_byte(8'h3C, 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_bytes();
      test_random_stream();
      test_pause_open_sequence();
      wait_until_drained();
      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("utf8_byte_stream_decoder test passed");
      end else begin
         $display("utf8_byte_stream_decoder test failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #(1_000_000);
      $display("utf8_byte_stream_decoder test failed");
      $finish;
   end

endmodule
